FILE: src/uer_pkg.sv
package uer_pkg;

    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int WAIT_W   = 20;
    localparam int CM_W     = 9;
    localparam int CNT_W    = 21;
    localparam int CM_DIV   = 58;
    localparam int REM_W    = 6;
    localparam int QUO_W    = 15;

    localparam logic [WAIT_W-1:0] MAX_WAIT_RST  = WAIT_W'(30000);
    localparam logic [CM_W-1:0]   MIN_RANGE_RST = CM_W'(3);
    localparam logic [CM_W-1:0]   MAX_RANGE_RST = CM_W'(300);

    typedef enum logic [1:0] {
        REG_MAX_WAIT  = 2'd0,
        REG_MIN_RANGE = 2'd1,
        REG_MAX_RANGE = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ECHO  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_START = 1'b1
    } req_type_t;

    typedef struct packed {
        logic req_type;
        logic echo_level;
    } req_t;

    typedef struct packed {
        logic [CM_W-1:0] dist_cm;
        status_t         status;
    } rsp_t;

    typedef struct packed {
        logic [WAIT_W-1:0] max_wait_us;
        logic [CM_W-1:0]   min_dist_cm;
        logic [CM_W-1:0]   max_dist_cm;
    } cfg_t;

endpackage

FILE: src/uer_apb_regs.sv
module uer_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uer_pkg::PADDR_W-1:0]   paddr,
    input  logic [uer_pkg::PDATA_W-1:0]   pwdata,
    output logic [uer_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output uer_pkg::cfg_t                 cfg
);
    import uer_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MAX_WAIT:  cfg_next.max_wait_us = pwdata[WAIT_W-1:0];
                REG_MIN_RANGE: cfg_next.min_dist_cm = pwdata[CM_W-1:0];
                REG_MAX_RANGE: cfg_next.max_dist_cm = pwdata[CM_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAX_WAIT:  prdata = PDATA_W'(cfg_reg.max_wait_us);
            REG_MIN_RANGE: prdata = PDATA_W'(cfg_reg.min_dist_cm);
            REG_MAX_RANGE: prdata = PDATA_W'(cfg_reg.max_dist_cm);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_wait_us <= MAX_WAIT_RST;
            cfg_reg.min_dist_cm <= MIN_RANGE_RST;
            cfg_reg.max_dist_cm <= MAX_RANGE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/uer_step.sv
module uer_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  uer_pkg::req_t req,
    input  uer_pkg::cfg_t cfg,
    output logic          res_valid,
    output uer_pkg::rsp_t res
);
    import uer_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic [QUO_W-1:0]   quo_reg;
    logic [QUO_W-1:0]   quo_next;
    logic [CNT_W-1:0]   count_inc;
    logic [CNT_W-1:0]   wait_limit;
    logic               rem_wrap;
    logic               cm_low;
    logic               cm_high;

    // width / 58 kept as running quotient and remainder during the high time
    assign count_inc  = count_reg + CNT_W'(1);
    assign wait_limit = CNT_W'(cfg.max_wait_us);
    assign rem_wrap   = (rem_reg == REM_W'(CM_DIV - 1));
    assign cm_low     = (quo_reg < QUO_W'(cfg.min_dist_cm));
    assign cm_high    = (quo_reg > QUO_W'(cfg.max_dist_cm));

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        res_valid   = 1'b0;
        res.dist_cm = '0;
        res.status  = ST_OK;
        if (req.req_type == REQ_START)
        begin
            phase_next = PH_WAIT;
            count_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (!req.echo_level)
                    begin
                        count_next = count_inc;
                        if (count_inc > wait_limit)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_NO_ECHO;
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HIGH;
                        count_next = CNT_W'(1);
                        rem_next   = REM_W'(1);
                        quo_next   = '0;
                        if (cfg.max_wait_us == '0)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_TOO_LONG;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_HIGH:
                begin
                    if (req.echo_level)
                    begin
                        count_next = count_inc;
                        rem_next   = rem_wrap ? '0 : rem_reg + REM_W'(1);
                        quo_next   = rem_wrap ? quo_reg + QUO_W'(1) : quo_reg;
                        if (count_inc > wait_limit)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_TOO_LONG;
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        phase_next = PH_IDLE;
                        if (cm_low || cm_high)
                        begin
                            res.status = ST_RANGE;
                        end
                        else
                        begin
                            res.dist_cm = quo_reg[CM_W-1:0];
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
        end
    end

endmodule

FILE: src/ultrasonic_echo_ranger_core.sv
// Ultrasonic echo ranger.
// Request channel (req_valid/req_ready/req_data): one transaction per item,
// either a start (arms a measurement) or a 1 us tick carrying the echo level.
// Response channel (rsp_valid/rsp_ready/rsp_data): at most one transaction per
// request, giving dist_cm and a status (ok, no echo, echo too long, out of
// range). dist_cm is zero unless status is ok.
// A request accepted into the input register is processed by the step logic
// once the response register is free or being taken, and its response is
// then registered in the response register and held there until taken.
// Throughput: one request per cycle while the receiver does not stall, set by
// the combinational step logic between the request and response registers.
// Configuration goes through the APB port: max_wait_us at 0x0, min_dist_cm at
// 0x4, max_dist_cm at 0x8; pready is always high.
// Reset returns the block to idle with default configuration and no pending
// transactions. While the receiver stalls with a response held, one more
// request is taken into the input register and req_ready then drops.
module ultrasonic_echo_ranger_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  uer_pkg::req_t                 req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output uer_pkg::rsp_t                 rsp_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uer_pkg::PADDR_W-1:0]   paddr,
    input  logic [uer_pkg::PDATA_W-1:0]   pwdata,
    output logic [uer_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import uer_pkg::*;

    cfg_t cfg;
    logic in_valid_reg;
    req_t in_data_reg;
    logic out_valid_reg;
    rsp_t out_data_reg;
    logic fire;
    logic step_valid;
    rsp_t step_res;

    assign fire      = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || fire;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    uer_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uer_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .req       (in_data_reg),
        .cfg       (cfg),
        .res_valid (step_valid),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire && step_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_data_reg <= req_data;
        end
        if (fire && step_valid)
        begin
            out_data_reg <= step_res;
        end
    end

endmodule

FILE: src/uer_checker.sv
module uer_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  uer_pkg::rsp_t                 rsp_data,
    input  logic                          pready
);
    import uer_pkg::*;

    // a held response transaction stays put until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_OK |-> rsp_data.dist_cm == '0)
        else $error("dist_cm set on error status");

    // request side only blocks when the response side is stalled
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("req_ready low without response stall");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .pready    (pready)
);
